@@ rtl/swm_pkg.sv @@
// Shared constants for the sliding window maximum block.
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(3);

endpackage

@@ rtl/swm_cell.sv @@
// One window cell: holds the maximum of the newest samples up to its depth.
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_head,
    input  logic                    i_advance,
    input  logic                    i_clear,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_prev_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_prev_max,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_max
);

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_max;
    logic                    n_valid;
    logic [SAMPLE_WIDTH-1:0] n_max;
    logic                    keep_prev;

    // Keep the neighbor's running max only if it is live and beats the new sample.
    assign keep_prev = ~i_head & ~i_clear & i_prev_valid &
                       ($signed(i_prev_max) > $signed(i_sample));
    assign n_valid   = i_head | (~i_clear & i_prev_valid);
    assign n_max     = keep_prev ? i_prev_max : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_max <= n_max;
        end
    end

    assign o_valid = r_valid;
    assign o_max   = r_max;

endmodule

@@ rtl/swm_out.sv @@
// Result stage: picks the cell of the configured depth and holds the output beat.
module swm_out
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int IDX_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [IDX_W-1:0]                         i_sel,
    input  logic [WINDOW_MAX-1:0]                    i_valid,
    input  logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0]  i_max,
    input  logic                                     i_tready,
    output logic                                     o_tvalid,
    output logic [DATA_W-1:0]                        o_tdata,
    output logic                                     o_free
);

    logic                    r_tvalid;
    logic [SAMPLE_WIDTH-1:0] r_data;
    logic                    hit;

    assign hit    = i_valid[i_sel];
    assign o_free = ~r_tvalid | i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (o_free) begin
            r_tvalid <= i_load & hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_max[i_sel];
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = DATA_W'(r_data);

endmodule

@@ rtl/sliding_window_maximum.sv @@
// Sliding window maximum over a stream of signed samples, built as a cell chain.
//
// Input beats arrive on s_axis: tdata carries the sample, tuser the start
// flag that empties the window before the sample enters. Once the window
// holds at least window_size samples, each input beat yields one output beat
// on m_axis carrying the largest of the newest window_size samples; earlier
// beats yield nothing. window_size is written on the cfg channel (always
// ready) while the stream is idle, a rule the user keeps and the block does
// not enforce; zero acts as one, values above WINDOW_MAX act as WINDOW_MAX.
// The change applies from the next sample. Cell k holds the maximum of the
// newest k+1 samples, so each beat costs one compare per cell and the chain
// advances in the cycle the beat lands. Beats pass the cell chain, then the
// output register; one beat per cycle is taken while the output is drained.
// When m_axis stalls, one beat waits in the chain and one in the output
// register; s_axis_tready then drops until the output register is taken.
// Reset empties the window, drops any pending beat and sets window_size to 3.
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_wdata,   // window_size
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // sample
    input  logic              s_axis_tuser,  // start_of_sequence
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata   // window_max
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SZ_W  = (CFG_W > $clog2(WINDOW_MAX + 1)) ? CFG_W
                                                             : $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]                        r_window_size;
    logic                                    r_pend;
    logic                                    accept;
    logic                                    out_free;
    logic [SZ_W-1:0]                         size_wide;
    logic [SZ_W-1:0]                         eff_size;
    logic [SZ_W-1:0]                         eff_last;
    logic [IDX_W-1:0]                        sel;
    logic [SAMPLE_WIDTH-1:0]                 sample;
    logic [WINDOW_MAX-1:0]                   cell_valid;
    logic [WINDOW_MAX-1:0][SAMPLE_WIDTH-1:0] cell_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RST;
        end else if (i_cfg_valid) begin
            r_window_size <= i_cfg_wdata;
        end
    end

    // Clamp the window size to 1..WINDOW_MAX and turn it into a cell index.
    assign size_wide = SZ_W'(r_window_size);
    always_comb begin
        if (size_wide == '0) begin
            eff_size = SZ_W'(1);
        end else if (size_wide > SZ_W'(WINDOW_MAX)) begin
            eff_size = SZ_W'(WINDOW_MAX);
        end else begin
            eff_size = size_wide;
        end
    end
    assign eff_last = eff_size - SZ_W'(1);
    assign sel      = eff_last[IDX_W-1:0];

    assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign s_axis_tready = ~r_pend | out_free;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // A beat in the chain waits here until the output register can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (out_free) begin
            r_pend <= 1'b0;
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic                    prev_valid;
        logic [SAMPLE_WIDTH-1:0] prev_max;
        if (g == 0) begin : g_head
            assign prev_valid = 1'b0;
            assign prev_max   = sample;
        end else begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign prev_max   = cell_max[g-1];
        end
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_head       ((g == 0) ? 1'b1 : 1'b0),
            .i_advance    (accept),
            .i_clear      (s_axis_tuser),
            .i_sample     (sample),
            .i_prev_valid (prev_valid),
            .i_prev_max   (prev_max),
            .o_valid      (cell_valid[g]),
            .o_max        (cell_max[g])
        );
    end

    swm_out #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDX_W        (IDX_W),
        .DATA_W       (DATA_W)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_pend),
        .i_sel    (sel),
        .i_valid  (cell_valid),
        .i_max    (cell_max),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_free   (out_free)
    );

endmodule

@@ test/sliding_window_maximum_tb.sv @@
// Self-checking testbench for sliding_window_maximum: directed and random streams.
module sliding_window_maximum_tb;
    import swm_pkg::*;

    localparam int DEPTH = WINDOW_MAX_DEF;
    localparam int SW    = SAMPLE_WIDTH_DEF;
    localparam int DW    = ((SW + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 4;

    typedef logic signed [SW-1:0] sample_t;

    localparam sample_t SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam sample_t SMAX = {1'b0, {(SW-1){1'b1}}};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [DW-1:0]    s_axis_tdata;   // sample
    logic             s_axis_tuser;   // start_of_sequence
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [DW-1:0]    m_axis_tdata;   // window_max

    sliding_window_maximum uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: its own copy of the window and the size register.
    sample_t          win_vals [DEPTH];
    bit               win_live [DEPTH];
    int               win_fill;
    logic [CFG_W-1:0] win_size;
    sample_t          max_q [$];

    int      mismatches;
    int      burst_left;
    int      gap_max;
    int      stall_mode;
    int      stall_left;
    sample_t last_sample;

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int eff_size(input logic [CFG_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > DEPTH)
            return DEPTH;
        return n;
    endfunction

    // Shift the sample into the window and queue the maximum if the window is full.
    function automatic void absorb_sample(input sample_t v, input bit sos);
        sample_t best;
        int      n;
        if (sos) begin
            foreach (win_live[i])
                win_live[i] = 1'b0;
            win_fill = 0;
        end
        for (int i = DEPTH - 1; i > 0; i--) begin
            win_vals[i] = win_vals[i-1];
            win_live[i] = win_live[i-1];
        end
        win_vals[0] = v;
        win_live[0] = 1'b1;
        if (win_fill < DEPTH)
            win_fill++;
        n = eff_size(win_size);
        if (win_fill >= n) begin
            best = win_vals[0];
            for (int i = 1; i < n; i++)
                if (win_live[i] && win_vals[i] > best)
                    best = win_vals[i];
            max_q = {max_q, best};
        end
    endfunction

    task automatic send_sample(input sample_t v, input bit sos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= sos;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_sample(v, sos);
        last_sample = v;
    endtask

    // Hold the sender until every queued maximum has come out, then let the chain settle.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (max_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_size = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMIN;
            1:       return SMAX;
            2:       return sample_t'($signed($urandom_range(0, 8)) - 4);
            3:       return last_sample - sample_t'($urandom_range(1, 3));
            4:       return last_sample + sample_t'($urandom_range(1, 3));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Receiver stall pattern: stretches of full rate, coin flips and long stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            2:       m_axis_tready <= $urandom_range(0, 1);
            3:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (max_q.size() == 0)
                report_mismatch($sformatf("unexpected beat window_max=%h", m_axis_tdata));
            else if (m_axis_tdata[SW-1:0] !== max_q[0])
                report_mismatch($sformatf("window_max got %h exp %h",
                                          m_axis_tdata[SW-1:0], max_q[0]));
            if (max_q.size() != 0)
                void'(max_q.pop_front());
        end
    end

    // Reset size of 3, extremes of the sample range and a clear mid-stream.
    task automatic test_default_size();
        gap_max = 0;
        send_sample(SMIN, 1'b1);
        send_sample(SMAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(SMIN, 1'b0);
        send_sample(SMIN, 1'b0);
        send_sample(SMIN, 1'b0);
        send_sample(5, 1'b1);
        send_sample(-7, 1'b0);
        send_sample(-8, 1'b0);
    endtask

    // Size changes without a clear, zero and oversize values.
    task automatic test_size_change();
        write_size(7'd5);
        send_sample(SMAX, 1'b0);
        send_sample(-2, 1'b0);
        write_size(7'd0);
        send_sample(3, 1'b0);
        send_sample(SMIN, 1'b0);
        write_size(7'd127);
        send_sample(9, 1'b0);
        send_sample(SMAX, 1'b1);
        write_size(7'd1);
        send_sample(-9, 1'b0);
        send_sample(SMIN, 1'b1);
    endtask

    // Fill the largest window and keep going so the oldest sample drops out.
    task automatic test_long_stream();
        write_size(7'd64);
        gap_max = 3;
        send_sample(SMAX, 1'b1);
        for (int i = 0; i < 139; i++)
            send_sample((i < 70) ? SMIN + sample_t'(i) : pick_sample(), 1'b0);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] size, input int count);
        int sent;
        int seq_len;
        write_size(size);
        case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 3;
            default: gap_max = 8;
        endcase
        sent = 0;
        while (sent < count) begin
            seq_len = $urandom_range(1, 2 * eff_size(size) + 10);
            for (int i = 0; i < seq_len && sent < count; i++) begin
                send_sample(pick_sample(), (i == 0) && ($urandom_range(0, 9) != 0));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(7'd1, 120);
        run_random_phase(7'd2, 120);
        run_random_phase(7'd64, 200);
        run_random_phase(7'd0, 100);
        run_random_phase(7'd127, 150);
        run_random_phase(7'd65, 100);
        for (int p = 0; p < 4; p++)
            run_random_phase(CFG_W'($urandom_range(0, 127)), 120);
        for (int p = 0; p < 5; p++)
            run_random_phase(CFG_W'($urandom_range(1, 16)), 85);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        gap_max       = 0;
        stall_mode    = 0;
        stall_left    = 0;
        last_sample   = '0;
        win_size      = WINDOW_SIZE_RST;
        win_fill      = 0;
        foreach (win_live[i]) begin
            win_live[i] = 1'b0;
            win_vals[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_size();
        test_size_change();
        test_long_stream();
        test_random();
        drain_results();

        if (max_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", max_q.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
